FILE: src/touch_gesture_classifier_core_defines.svh
// ---------------------------------------------------------------------------
// Touch gesture classifier assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tgc_pkg.sv
// ---------------------------------------------------------------------------
// Touch gesture classifier package
// Codes, configuration record and pipeline snapshot types.
// ---------------------------------------------------------------------------
package tgc_pkg;

	localparam int unsigned COORD_W    = 10;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Report kinds from the touch controller.
	typedef enum logic [1:0] {
		EV_DOWN    = 2'd0,
		EV_UP      = 2'd1,
		EV_CONTACT = 2'd2,
		EV_OTHER   = 2'd3
	} event_kind_t;

	// Gesture codes.
	typedef enum logic [2:0] {
		G_NONE  = 3'd0,
		G_UP    = 3'd1,
		G_LEFT  = 3'd2,
		G_DOWN  = 3'd3,
		G_RIGHT = 3'd4,
		G_SLASH = 3'd5,
		G_TAP   = 3'd6,
		G_LONG  = 3'd7
	} gesture_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_HEIGHT = 3'd0,
		CFG_MIN_SWIPE     = 3'd1,
		CFG_MAX_TAP_DIST  = 3'd2,
		CFG_MAX_TAP_MS    = 3'd3,
		CFG_MIN_LONG_MS   = 3'd4,
		CFG_TIMEOUT_MS    = 3'd5,
		CFG_TAN_Q8        = 3'd6,
		CFG_ZONE_WIDTH    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [8:0]  panel_height;
		logic [9:0]  swipe_min_len;
		logic [9:0]  tap_max_len;
		logic [15:0] max_tap_ms;
		logic [15:0] min_long_press_ms;
		logic [15:0] touch_timeout_ms;
		logic [8:0]  swipe_angle_tan_q8;
		logic [8:0]  slash_zone_width;
	} cfg_t;

	// Stroke summary handed from the tracking stage to the classifier.
	typedef struct packed {
		logic       active;
		logic [7:0] abs_vx;
		logic [9:0] abs_u;
		logic       vx_neg;
		logic       vx_pos;
		logic       u_neg;
		logic       u_pos;
		logic       zero_vec;
		logic       slash_zone;
		logic       dur_short;
		logic       dur_long;
	} snap_t;

endpackage

FILE: src/tgc_ifs.sv
// ---------------------------------------------------------------------------
// Touch gesture classifier channel interfaces
// Valid/ready channels for touch reports and gesture results.
// ---------------------------------------------------------------------------
interface tgc_touch_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [7:0]  raw_x;
	logic [7:0]  raw_y;
	logic [31:0] time_ms;

	modport source (output valid, event_kind, raw_x, raw_y, time_ms, input ready);
	modport sink (input valid, event_kind, raw_x, raw_y, time_ms, output ready);
endinterface

interface tgc_result_if;
	logic              valid;
	logic              ready;
	logic [2:0]        gesture;
	logic              point_valid;
	logic signed [9:0] point_x;
	logic signed [9:0] point_y;

	modport source (output valid, gesture, point_valid, point_x, point_y, input ready);
	modport sink (input valid, gesture, point_valid, point_x, point_y, output ready);
endinterface

FILE: src/touch_gesture_classifier_core.sv
// ---------------------------------------------------------------------------
// Touch gesture classifier core
// Tracks touch strokes from controller reports and classifies each finished
// stroke as a swipe, a down slash, a tap or a long press.
// ---------------------------------------------------------------------------
//  channel  | role   | payload
//  ---------+--------+-----------------------------------------------
//  touch    | sink   | event_kind, raw_x, raw_y, time_ms
//  result   | source | gesture, point_valid, point_x, point_y
//  cfg_*    | write  | cfg_index selects one of eight registers
//
// One report can be taken in every cycle while no held result stalls it; each
// report moves through the input register, then the output register: the only stages.
// The stroke state is updated as a report moves into the output register.
// A held result stalls the input register; touch.ready drops only while both
// registers are full and result.ready is low.
// Reset empties both registers, clears the stroke state and restores the default
// configuration.
// ---------------------------------------------------------------------------
`include "touch_gesture_classifier_core_defines.svh"

module touch_gesture_classifier_core
	import tgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tgc_touch_if.sink             touch,
	tgc_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;

	// Stage 1: input register.
	logic        v_s1;
	event_kind_t kind_s1;
	logic [7:0]  rx_s1;
	logic [7:0]  ry_s1;
	logic [31:0] time_s1;

	// Stroke state.
	logic        have_start_q;
	logic        have_cur_q;
	coord_t      start_x_q;
	coord_t      start_y_q;
	coord_t      cur_x_q;
	coord_t      cur_y_q;
	logic [31:0] start_time_q;
	logic [31:0] last_time_q;

	// Output register.
	logic     out_v_q;
	gesture_t gesture_q;
	logic     pv_q;
	coord_t   px_q;
	coord_t   py_q;

	gesture_t gesture_d;

	logic rdy_o, rdy1;
	logic adv1;

	coord_t             new_x;
	coord_t             new_y;
	logic [31:0]        age;
	logic               timed_out;
	logic               closing;
	logic signed [10:0] vx;
	logic signed [10:0] vy;
	logic signed [10:0] abs_vx_w;
	logic signed [10:0] abs_vy_w;
	logic [31:0]        dur;
	logic signed [10:0] zone_hi;
	snap_t              snap_d;

	// Handshake: the input register moves on when the output register is empty or moving.
	always_comb begin
		rdy_o = !out_v_q || result.ready;
		rdy1  = !v_s1 || rdy_o;
		adv1  = v_s1 && rdy_o;
	end

	assign touch.ready = rdy1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_height       <= 9'd240;
			cfg_q.swipe_min_len      <= 10'd30;
			cfg_q.tap_max_len        <= 10'd20;
			cfg_q.max_tap_ms         <= 16'd300;
			cfg_q.min_long_press_ms  <= 16'd800;
			cfg_q.touch_timeout_ms   <= 16'd500;
			cfg_q.swipe_angle_tan_q8 <= 9'd256;
			cfg_q.slash_zone_width   <= 9'd40;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SCREEN_HEIGHT: cfg_q.panel_height       <= cfg_wdata[8:0];
				CFG_MIN_SWIPE:     cfg_q.swipe_min_len      <= cfg_wdata[9:0];
				CFG_MAX_TAP_DIST:  cfg_q.tap_max_len        <= cfg_wdata[9:0];
				CFG_MAX_TAP_MS:    cfg_q.max_tap_ms         <= cfg_wdata;
				CFG_MIN_LONG_MS:   cfg_q.min_long_press_ms  <= cfg_wdata;
				CFG_TIMEOUT_MS:    cfg_q.touch_timeout_ms   <= cfg_wdata;
				CFG_TAN_Q8:        cfg_q.swipe_angle_tan_q8 <= cfg_wdata[8:0];
				CFG_ZONE_WIDTH:    cfg_q.slash_zone_width   <= cfg_wdata[8:0];
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= touch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (touch.valid && rdy1) begin
			kind_s1 <= event_kind_t'(touch.event_kind);
			rx_s1   <= touch.raw_x;
			ry_s1   <= touch.raw_y;
			time_s1 <= touch.time_ms;
		end
	end

	// Point mapping, timeout and stroke summary from the current state.
	always_comb begin
		new_x     = coord_t'({2'b00, ry_s1});
		new_y     = coord_t'({1'b0, cfg_q.panel_height} - {2'b00, rx_s1});
		age       = time_s1 - last_time_q;
		timed_out = age > {16'b0, cfg_q.touch_timeout_ms};
		closing   = (kind_s1 == EV_UP) || ((kind_s1 == EV_OTHER) && timed_out);
		vx        = {cur_x_q[9], cur_x_q} - {start_x_q[9], start_x_q};
		vy        = {cur_y_q[9], cur_y_q} - {start_y_q[9], start_y_q};
		abs_vx_w  = (vx < 0) ? -vx : vx;
		abs_vy_w  = (vy < 0) ? -vy : vy;
		dur       = last_time_q - start_time_q;
		zone_hi   = $signed({2'b00, cfg_q.panel_height})
		          - $signed({2'b00, cfg_q.slash_zone_width});

		snap_d.active     = closing && have_start_q && have_cur_q;
		snap_d.abs_vx     = abs_vx_w[7:0];
		snap_d.abs_u      = abs_vy_w[9:0];
		snap_d.vx_neg     = vx < 0;
		snap_d.vx_pos     = vx > 0;
		snap_d.u_neg      = vy > 0;
		snap_d.u_pos      = vy < 0;
		snap_d.zero_vec   = (vx == 0) && (vy == 0);
		snap_d.slash_zone = ($signed({cur_y_q[9], cur_y_q}) > zone_hi)
		                 && ($signed({start_y_q[9], start_y_q})
		                     < $signed({2'b00, cfg_q.slash_zone_width}));
		snap_d.dur_short  = dur < {16'b0, cfg_q.max_tap_ms};
		snap_d.dur_long   = dur > {16'b0, cfg_q.min_long_press_ms};
	end

	// Stroke tracking, updated as each report leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_start_q <= 1'b0;
			have_cur_q   <= 1'b0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			start_time_q <= '0;
			last_time_q  <= '0;
		end else if (adv1) begin
			unique case (kind_s1)
				EV_DOWN: begin
					have_start_q <= 1'b1;
					have_cur_q   <= 1'b1;
					start_x_q    <= new_x;
					start_y_q    <= new_y;
					cur_x_q      <= new_x;
					cur_y_q      <= new_y;
					start_time_q <= time_s1;
					last_time_q  <= time_s1;
				end
				EV_CONTACT: begin
					if (!have_start_q) begin
						have_start_q <= 1'b1;
						start_x_q    <= new_x;
						start_y_q    <= new_y;
						start_time_q <= time_s1;
					end
					have_cur_q  <= 1'b1;
					cur_x_q     <= new_x;
					cur_y_q     <= new_y;
					last_time_q <= time_s1;
				end
				EV_UP, EV_OTHER: begin
					if (snap_d.active) begin
						have_start_q <= 1'b0;
						have_cur_q   <= 1'b0;
						start_time_q <= '0;
						last_time_q  <= '0;
					end
				end
			endcase
		end
	end

	tgc_classify u_classify (
		.snap    (snap_d),
		.cfg     (cfg_q),
		.gesture (gesture_d)
	);

	// Output register: the gesture and the point before this report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_o) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			gesture_q <= gesture_d;
			pv_q      <= have_cur_q;
			px_q      <= have_cur_q ? cur_x_q : '0;
			py_q      <= have_cur_q ? cur_y_q : '0;
		end
	end

	assign result.valid       = out_v_q;
	assign result.gesture     = gesture_q;
	assign result.point_valid = pv_q;
	assign result.point_x     = px_q;
	assign result.point_y     = py_q;

	// The start and current points are always opened and closed together.
	`TGC_ASSERT_IMPL(a_flags_agree, clk, arst_n, 1'b1, have_start_q == have_cur_q, "stroke flags disagree")
	// A down report opens a stroke stamped with its own time.
	`TGC_ASSERT_NEXT(a_down_opens, clk, arst_n, adv1 && (kind_s1 == EV_DOWN), have_start_q && (start_time_q == $past(time_s1)), "down report did not open a stroke")
	// A gesture can only come from a tracked stroke.
	`TGC_ASSERT_IMPL(a_gesture_tracked, clk, arst_n, out_v_q && (gesture_q != G_NONE), pv_q, "gesture without a tracked point")
	// A result that is not taken stays unchanged.
	`TGC_ASSERT_NEXT(a_out_holds, clk, arst_n, out_v_q && !result.ready, out_v_q && $stable(gesture_q) && $stable(px_q) && $stable(py_q), "result changed while stalled")

endmodule

FILE: src/tgc_classify.sv
// ---------------------------------------------------------------------------
// Touch gesture stroke classifier
// Forms the squared lengths and tangent products of a stroke summary, then
// picks the swipe sector or the tap / long press fallback.
// ---------------------------------------------------------------------------
module tgc_classify
	import tgc_pkg::*;
(
	input  snap_t    snap,
	input  cfg_t     cfg,
	output gesture_t gesture
);

	logic [15:0] sq_vx;
	logic [19:0] sq_u;
	logic [19:0] dsw2;
	logic [19:0] dtap2;
	logic [18:0] tu;
	logic [16:0] tv;

	logic [20:0] n2;
	logic        long_enough;
	logic        short_enough;
	logic [15:0] vx_sh;
	logic [17:0] u_sh;
	logic        sec_up;
	logic        sec_left;
	logic        sec_down;
	logic        sec_right;

	// Small products, then the length and sector tests.
	always_comb begin
		sq_vx        = 16'(snap.abs_vx) * 16'(snap.abs_vx);
		sq_u         = 20'(snap.abs_u) * 20'(snap.abs_u);
		dsw2         = 20'(cfg.swipe_min_len) * 20'(cfg.swipe_min_len);
		dtap2        = 20'(cfg.tap_max_len) * 20'(cfg.tap_max_len);
		tu           = 19'(cfg.swipe_angle_tan_q8) * 19'(snap.abs_u);
		tv           = 17'(cfg.swipe_angle_tan_q8) * 17'(snap.abs_vx);
		n2           = 21'(sq_vx) + 21'(sq_u);
		long_enough  = n2 >= 21'(dsw2);
		short_enough = n2 < 21'(dtap2);
		vx_sh        = {snap.abs_vx, 8'b0};
		u_sh         = {snap.abs_u, 8'b0};
		sec_up       = snap.u_pos && (19'(vx_sh) < tu);
		sec_left     = snap.vx_neg && (u_sh < 18'(tv));
		sec_down     = snap.u_neg && (19'(vx_sh) < tu);
		sec_right    = (snap.vx_pos && (u_sh < 18'(tv)))
		            || (snap.zero_vec && (cfg.swipe_angle_tan_q8 != 9'd0));
	end

	// Sector order decides where sectors overlap; tap tests come last.
	always_comb begin
		priority if (!snap.active) begin
			gesture = G_NONE;
		end else if (long_enough && sec_up) begin
			gesture = G_UP;
		end else if (long_enough && sec_left) begin
			gesture = G_LEFT;
		end else if (long_enough && sec_down) begin
			gesture = snap.slash_zone ? G_SLASH : G_DOWN;
		end else if (long_enough && sec_right) begin
			gesture = G_RIGHT;
		end else if (short_enough && snap.dur_short) begin
			gesture = G_TAP;
		end else if (short_enough && snap.dur_long) begin
			gesture = G_LONG;
		end else begin
			gesture = G_NONE;
		end
	end

endmodule

FILE: tb/touch_gesture_classifier_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Touch gesture classifier core testbench
// Feeds touch reports through the valid/ready touch channel and compares each
// gesture result with a behavioral tracker of the stroke state. Directed
// strokes come first. Random strokes follow under several register settings,
// with random gaps on both channels, a long output hold-off and a stretch
// with no gaps at all.
// ---------------------------------------------------------------------------
module touch_gesture_classifier_core_tb;
	import tgc_pkg::*;

	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		gesture_t gesture;
		logic     point_valid;
		coord_t   point_x;
		coord_t   point_y;
	} gesture_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tgc_touch_if  touch_ch ();
	tgc_result_if result_ch ();

	touch_gesture_classifier_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.touch     (touch_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Tracker state, mirrored from the block.
	cfg_t        gesture_cfg;
	logic        stroke_open;
	logic        point_held;
	int          start_x, start_y, cur_x, cur_y;
	logic [31:0] start_ms, last_ms;

	gesture_result_t pending_gestures[$];
	int          mismatch_count;
	int          reports_sent;
	logic [31:0] clock_ms;
	logic        source_gaps;
	logic        sink_stalls;
	logic        hold_request;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	function automatic cfg_t default_settings();
		return '{panel_height: 9'd240, swipe_min_len: 10'd30, tap_max_len: 10'd20,
			max_tap_ms: 16'd300, min_long_press_ms: 16'd800, touch_timeout_ms: 16'd500,
			swipe_angle_tan_q8: 9'd256, slash_zone_width: 9'd40};
	endfunction

	function automatic void open_stroke(input int px, input int py, input logic [31:0] now);
		stroke_open = 1'b1;
		point_held  = 1'b1;
		start_x     = px;
		start_y     = py;
		cur_x       = px;
		cur_y       = py;
		start_ms    = now;
		last_ms     = now;
	endfunction

	// Swipe sectors are tested as up, left, down, right; the first match wins.
	function automatic gesture_t swipe_direction();
		longint vx, u, ax, au, d, t, zone;
		vx = longint'(cur_x - start_x);
		u  = longint'(start_y - cur_y);
		ax = (vx < 0) ? -vx : vx;
		au = (u < 0) ? -u : u;
		d  = longint'(gesture_cfg.swipe_min_len);
		t  = longint'(gesture_cfg.swipe_angle_tan_q8);
		if (vx * vx + u * u < d * d)
			return G_NONE;
		if (u > 0 && ax * 256 < t * u)
			return G_UP;
		if (vx < 0 && au * 256 < t * (-vx))
			return G_LEFT;
		if (u < 0 && ax * 256 < t * (-u)) begin
			zone = longint'(gesture_cfg.slash_zone_width);
			if (longint'(cur_y) > longint'(gesture_cfg.panel_height) - zone
					&& longint'(start_y) < zone)
				return G_SLASH;
			return G_DOWN;
		end
		if (vx > 0 && au * 256 < t * vx)
			return G_RIGHT;
		if (vx == 0 && u == 0 && t > 0)
			return G_RIGHT;
		return G_NONE;
	endfunction

	// A short stroke falls back to tap or long press by its duration.
	function automatic gesture_t tap_or_press();
		longint vx, vy, d;
		logic [31:0] dur;
		vx  = longint'(cur_x - start_x);
		vy  = longint'(cur_y - start_y);
		d   = longint'(gesture_cfg.tap_max_len);
		dur = last_ms - start_ms;
		if (vx * vx + vy * vy < d * d) begin
			if (dur < 32'(gesture_cfg.max_tap_ms))
				return G_TAP;
			if (dur > 32'(gesture_cfg.min_long_press_ms))
				return G_LONG;
		end
		return G_NONE;
	endfunction

	// Applies one report to the tracker and returns the result it causes.
	function automatic gesture_result_t track_report(input event_kind_t kind,
			input logic [7:0] rx, input logic [7:0] ry, input logic [31:0] now);
		gesture_result_t r;
		int px, py;
		logic [31:0] age;
		px            = int'(ry);
		py            = int'(gesture_cfg.panel_height) - int'(rx);
		age           = now - last_ms;
		r.gesture     = G_NONE;
		r.point_valid = point_held;
		r.point_x     = point_held ? coord_t'(cur_x) : '0;
		r.point_y     = point_held ? coord_t'(cur_y) : '0;
		case (kind)
			EV_DOWN: begin
				open_stroke(px, py, now);
			end
			EV_CONTACT: begin
				if (!stroke_open) begin
					open_stroke(px, py, now);
				end else begin
					cur_x      = px;
					cur_y      = py;
					point_held = 1'b1;
					last_ms    = now;
				end
			end
			default: begin
				if ((kind == EV_UP || age > 32'(gesture_cfg.touch_timeout_ms))
						&& stroke_open && point_held) begin
					r.gesture = swipe_direction();
					if (r.gesture == G_NONE)
						r.gesture = tap_or_press();
					stroke_open = 1'b0;
					point_held  = 1'b0;
					start_ms    = '0;
					last_ms     = '0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offers one report and waits for its transfer; valid stays high afterwards.
	task automatic send_report(input event_kind_t kind, input logic [7:0] rx,
			input logic [7:0] ry, input logic [31:0] stamp);
		while (source_gaps && $urandom_range(99) < 21) begin
			touch_ch.valid <= 1'b0;
			@(posedge clk);
		end
		touch_ch.valid      <= 1'b1;
		touch_ch.event_kind <= kind;
		touch_ch.raw_x      <= rx;
		touch_ch.raw_y      <= ry;
		touch_ch.time_ms    <= stamp;
		@(posedge clk);
		while (!touch_ch.ready)
			@(posedge clk);
		pending_gestures.push_back(track_report(kind, rx, ry, stamp));
		reports_sent++;
	endtask

	// Stops offering reports and waits until every result has arrived.
	task automatic drain_results();
		touch_ch.valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// Writes every register with the block idle.
	task automatic load_settings(input cfg_t c);
		drain_results();
		write_register(CFG_SCREEN_HEIGHT, 16'(c.panel_height));
		write_register(CFG_MIN_SWIPE, 16'(c.swipe_min_len));
		write_register(CFG_MAX_TAP_DIST, 16'(c.tap_max_len));
		write_register(CFG_MAX_TAP_MS, c.max_tap_ms);
		write_register(CFG_MIN_LONG_MS, c.min_long_press_ms);
		write_register(CFG_TIMEOUT_MS, c.touch_timeout_ms);
		write_register(CFG_TAN_Q8, 16'(c.swipe_angle_tan_q8));
		write_register(CFG_ZONE_WIDTH, 16'(c.slash_zone_width));
		cfg_we      <= 1'b0;
		gesture_cfg  = c;
	endtask

	// Time between reports: mostly short, sometimes long, now and then anything.
	function automatic logic [31:0] pick_gap();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return $urandom_range(0, 400);
		if (pick < 9)
			return $urandom_range(400, 1500);
		return $urandom;
	endfunction

	function automatic logic [7:0] clamp_raw(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	// One stroke: a start, a few moves along a heading, then an ending.
	task automatic random_stroke();
		int rx, ry, heading, reach, jitter, moves;
		rx      = $urandom_range(0, 255);
		ry      = $urandom_range(0, 255);
		heading = $urandom_range(0, 4);
		case ($urandom_range(0, 2))
			0:       reach = $urandom_range(0, 3);
			1:       reach = $urandom_range(3, 20);
			default: reach = $urandom_range(20, 90);
		endcase
		moves = $urandom_range(0, 4);
		clock_ms += pick_gap();
		send_report(($urandom_range(0, 3) == 0) ? EV_CONTACT : EV_DOWN, 8'(rx), 8'(ry),
			clock_ms);
		for (int m = 0; m < moves; m++) begin
			clock_ms += pick_gap();
			if ($urandom_range(0, 9) == 0)
				send_report(EV_OTHER, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					clock_ms);
			jitter = $urandom_range(0, reach / 3);
			if ($urandom_range(0, 1) != 0)
				jitter = -jitter;
			case (heading)
				0: begin rx += reach; ry += jitter; end
				1: begin ry -= reach; rx += jitter; end
				2: begin rx -= reach; ry += jitter; end
				3: begin ry += reach; rx += jitter; end
				default: begin
					rx += $urandom_range(0, 2 * reach) - reach;
					ry += $urandom_range(0, 2 * reach) - reach;
				end
			endcase
			rx = int'(clamp_raw(rx));
			ry = int'(clamp_raw(ry));
			send_report(EV_CONTACT, 8'(rx), 8'(ry), clock_ms);
		end
		case ($urandom_range(0, 19))
			0: ; // Left open; the next down restarts it.
			1, 2, 3, 4, 5: begin
				clock_ms += 32'(gesture_cfg.touch_timeout_ms) + $urandom_range(0, 60);
				send_report(EV_OTHER, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					clock_ms);
			end
			default: begin
				clock_ms += $urandom_range(0, 50);
				send_report(EV_UP, clamp_raw(rx + $urandom_range(0, 2) - 1), 8'(ry), clock_ms);
			end
		endcase
	endtask

	// A report with every field at random.
	task automatic random_report();
		event_kind_t kind;
		logic [31:0] stamp;
		kind = event_kind_t'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0)
			stamp = $urandom;
		else
			stamp = clock_ms + pick_gap();
		clock_ms = stamp;
		send_report(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), stamp);
	endtask

	// Mixed traffic: well-formed strokes with some noise between them.
	task automatic run_traffic(input int items, input int noise_pct);
		int stop_at;
		stop_at = reports_sent + items;
		while (reports_sent < stop_at) begin
			if ($urandom_range(0, 99) < noise_pct)
				random_report();
			else
				random_stroke();
		end
	endtask

	function automatic cfg_t random_settings();
		cfg_t c;
		c.panel_height       = ($urandom_range(1, 4) == 1) ? 9'($urandom_range(1, 511))
			: 9'($urandom_range(180, 320));
		c.swipe_min_len      = 10'($urandom_range(0, 120));
		c.tap_max_len        = 10'($urandom_range(0, 60));
		c.max_tap_ms         = 16'($urandom_range(0, 600));
		c.min_long_press_ms  = 16'($urandom_range(200, 1200));
		c.touch_timeout_ms   = 16'($urandom_range(0, 1000));
		c.swipe_angle_tan_q8 = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(257, 511))
			: 9'($urandom_range(0, 256));
		c.slash_zone_width   = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
			: 9'($urandom_range(0, 100));
		return c;
	endfunction

	// Each named gesture once, plus the cases with nothing tracked.
	task automatic test_directed();
		gesture_cfg = default_settings();
		send_report(EV_UP, 8'd10, 8'd10, 32'd10);
		send_report(EV_OTHER, 8'd20, 8'd20, 32'd900);
		// Tap.
		send_report(EV_DOWN, 8'd128, 8'd128, 32'd1000);
		send_report(EV_CONTACT, 8'd130, 8'd129, 32'd1050);
		send_report(EV_UP, 8'd130, 8'd129, 32'd1100);
		// Long press.
		send_report(EV_DOWN, 8'd128, 8'd128, 32'd2000);
		send_report(EV_CONTACT, 8'd129, 8'd128, 32'd2900);
		send_report(EV_UP, 8'd129, 8'd128, 32'd2950);
		// Short stroke of middling duration gives no gesture.
		send_report(EV_DOWN, 8'd128, 8'd128, 32'd3000);
		send_report(EV_CONTACT, 8'd128, 8'd128, 32'd3500);
		send_report(EV_UP, 8'd128, 8'd128, 32'd3600);
		// Swipe up, opened by a contact with no stroke.
		send_report(EV_CONTACT, 8'd100, 8'd100, 32'd4000);
		send_report(EV_CONTACT, 8'd160, 8'd100, 32'd4050);
		send_report(EV_UP, 8'd160, 8'd100, 32'd4060);
		// Swipe left, ended by an other report after the timeout.
		send_report(EV_DOWN, 8'd100, 8'd200, 32'd5000);
		send_report(EV_CONTACT, 8'd100, 8'd100, 32'd5100);
		send_report(EV_OTHER, 8'd0, 8'd0, 32'd5200);
		send_report(EV_OTHER, 8'd0, 8'd0, 32'd5700);
		// Swipe down outside the slash zones.
		send_report(EV_DOWN, 8'd150, 8'd128, 32'd6000);
		send_report(EV_CONTACT, 8'd60, 8'd128, 32'd6100);
		send_report(EV_UP, 8'd60, 8'd128, 32'd6110);
		// Down slash from the top edge to the bottom edge.
		send_report(EV_DOWN, 8'd255, 8'd64, 32'd7000);
		send_report(EV_CONTACT, 8'd0, 8'd64, 32'd7100);
		send_report(EV_UP, 8'd0, 8'd64, 32'd7110);
		// Swipe right across the timestamp wrap.
		send_report(EV_DOWN, 8'd120, 8'd0, 32'hFFFF_FFFF);
		send_report(EV_CONTACT, 8'd120, 8'd255, 32'h0000_0020);
		send_report(EV_UP, 8'd120, 8'd255, 32'h0000_0030);
	endtask

	task automatic test_default_strokes();
		clock_ms = 32'd10000;
		run_traffic(200, 10);
	endtask

	// Zero limits and tangent: no stroke is a swipe; each is a long press or nothing.
	task automatic test_low_limits();
		load_settings('{panel_height: 9'd511, swipe_min_len: 10'd0,
			tap_max_len: 10'd1023, max_tap_ms: 16'd0, min_long_press_ms: 16'd0,
			touch_timeout_ms: 16'd0, swipe_angle_tan_q8: 9'd0, slash_zone_width: 9'd0});
		run_traffic(100, 15);
	endtask

	// Top limits and a wide tangent, starting just short of the wrap.
	task automatic test_high_limits();
		load_settings('{panel_height: 9'd1, swipe_min_len: 10'd1023,
			tap_max_len: 10'd0, max_tap_ms: 16'd65535, min_long_press_ms: 16'd65535,
			touch_timeout_ms: 16'd65535, swipe_angle_tan_q8: 9'd511, slash_zone_width: 9'd511});
		clock_ms = 32'hFFFF_F000;
		run_traffic(100, 15);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 5; p++) begin
			load_settings(random_settings());
			run_traffic(80, 10);
		end
	endtask

	// The output holds off while reports keep coming, so the pipeline fills.
	task automatic test_output_hold_off();
		load_settings(default_settings());
		source_gaps  = 1'b0;
		hold_request = 1'b1;
		run_traffic(40, 0);
		source_gaps  = 1'b1;
	endtask

	task automatic test_back_to_back();
		load_settings(random_settings());
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		run_traffic(150, 10);
		source_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	task automatic test_noise();
		load_settings(random_settings());
		run_traffic(60, 100);
	endtask

	// Result sink: random stalls, plus one long hold-off when asked.
	initial begin : result_sink
		int hold_left;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !(sink_stalls && $urandom_range(99) < 21);
			end
		end
	end

	// Each result transfer is compared with the oldest expectation.
	initial begin : result_checker
		gesture_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (pending_gestures.size() == 0) begin
					flag_mismatch("result with no report waiting");
				end else begin
					want = pending_gestures.pop_front();
					if (result_ch.gesture !== want.gesture)
						flag_mismatch($sformatf("gesture %0d, expected %0d",
							result_ch.gesture, want.gesture));
					if (result_ch.point_valid !== want.point_valid)
						flag_mismatch($sformatf("point_valid %b, expected %b",
							result_ch.point_valid, want.point_valid));
					if (result_ch.point_x !== want.point_x)
						flag_mismatch($sformatf("point_x %0d, expected %0d",
							result_ch.point_x, want.point_x));
					if (result_ch.point_y !== want.point_y)
						flag_mismatch($sformatf("point_y %0d, expected %0d",
							result_ch.point_y, want.point_y));
				end
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		touch_ch.valid      = 1'b0;
		touch_ch.event_kind = '0;
		touch_ch.raw_x      = '0;
		touch_ch.raw_y      = '0;
		touch_ch.time_ms    = '0;
		source_gaps         = 1'b1;
		sink_stalls         = 1'b1;
		hold_request        = 1'b0;
		mismatch_count      = 0;
		reports_sent        = 0;
		clock_ms            = '0;
		gesture_cfg         = default_settings();
		stroke_open         = 1'b0;
		point_held          = 1'b0;
		start_x             = 0;
		start_y             = 0;
		cur_x               = 0;
		cur_y               = 0;
		start_ms            = '0;
		last_ms             = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_default_strokes();
		test_low_limits();
		test_high_limits();
		test_random_settings();
		test_output_hold_off();
		test_back_to_back();
		test_noise();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
